// ----- sv/lot_pkg.sv -----
`default_nettype none
package lot_pkg;

	localparam int ENTRIES  = 16;
	localparam int SLOT_W   = $clog2(ENTRIES);
	localparam int CNT_W    = $clog2(ENTRIES + 1);
	localparam int TAG_W    = 16;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	typedef enum logic [KIND_W-1:0] {
		K_ADD    = 2'd0,
		K_REMOVE = 2'd1,
		K_POKE   = 2'd2,
		K_POP    = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_NOOP  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_LOOK = 2'd1,
		S_UPD  = 2'd2
	} state_t;

	typedef struct packed {
		logic load;
		logic look;
		logic update;
	} cmd_t;

endpackage
`default_nettype wire

// ----- sv/lot_ctrl.sv -----
`default_nettype none
module lot_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output lot_pkg::cmd_t      cmd
);

	lot_pkg::state_t state_q;
	lot_pkg::state_t state_n;
	logic            accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lot_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// The update state also takes a new request while the last one is committed.
	always_comb begin
		busy       = (state_q == lot_pkg::S_LOOK);
		accept     = start && !busy;
		cmd.load   = accept;
		cmd.look   = (state_q == lot_pkg::S_LOOK);
		cmd.update = (state_q == lot_pkg::S_UPD);
		case (state_q)
			lot_pkg::S_IDLE: begin
				state_n = accept ? lot_pkg::S_LOOK : lot_pkg::S_IDLE;
			end
			lot_pkg::S_LOOK: begin
				state_n = lot_pkg::S_UPD;
			end
			lot_pkg::S_UPD: begin
				state_n = accept ? lot_pkg::S_LOOK : lot_pkg::S_IDLE;
			end
			default: begin
				state_n = lot_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- sv/lot_dp.sv -----
`default_nettype none
module lot_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lot_pkg::cmd_t                 cmd,
	input  wire logic [lot_pkg::KIND_W-1:0]    kind,
	input  wire logic [lot_pkg::TAG_W-1:0]     tag,
	output logic                               done,
	output logic [lot_pkg::TAG_W-1:0]          popped_tag,
	output logic [lot_pkg::STATUS_W-1:0]       status,
	output logic [lot_pkg::OCC_W-1:0]          occupancy
);

	localparam int N = lot_pkg::ENTRIES;

	// Per-slot state: each valid slot holds its age rank, zero being the oldest.
	logic [N-1:0]                    valid_q;
	logic [lot_pkg::TAG_W-1:0]       tag_q   [N];
	logic [lot_pkg::SLOT_W-1:0]      rank_q  [N];
	logic [lot_pkg::CNT_W-1:0]       count_q;

	lot_pkg::kind_t                  kind_q;
	logic [lot_pkg::TAG_W-1:0]       req_tag_q;

	// Lookup results.
	logic [N-1:0]                    match_c, oldest_c, free_c, inv_c;
	logic [lot_pkg::SLOT_W-1:0]      mrank_c;
	logic [lot_pkg::TAG_W-1:0]       otag_c;
	logic [N-1:0]                    match_s1, oldest_s1, free_s1;
	logic [lot_pkg::SLOT_W-1:0]      mrank_s1;
	logic [lot_pkg::TAG_W-1:0]       otag_s1;
	logic                            hit_s1, full_s1, empty_s1, newest_s1;

	// Update decisions.
	lot_pkg::status_t                status_c;
	logic [lot_pkg::TAG_W-1:0]       popped_c;
	logic                            rm_en, ins_en, touch_en;
	logic [N-1:0]                    rm_oh;
	logic [lot_pkg::SLOT_W-1:0]      rm_rank;
	logic [N-1:0]                    valid_n;
	logic [lot_pkg::SLOT_W-1:0]      rank_n  [N];
	logic [lot_pkg::CNT_W-1:0]       cnt_n;
	logic [lot_pkg::CNT_W-1:0]       cnt_dec;
	logic [lot_pkg::OCC_W+lot_pkg::CNT_W-1:0] occ_wide;

	logic                            done_q;
	logic [lot_pkg::TAG_W-1:0]       popped_q;
	lot_pkg::status_t                status_q;
	logic [lot_pkg::OCC_W-1:0]       occ_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= lot_pkg::kind_t'(kind);
			req_tag_q <= tag;
		end
	end

	always_comb begin
		mrank_c = '0;
		otag_c  = '0;
		for (int i = 0; i < N; i++) begin
			match_c[i]  = valid_q[i] && (tag_q[i] == req_tag_q);
			oldest_c[i] = valid_q[i] && (rank_q[i] == '0);
			mrank_c     = mrank_c | (match_c[i] ? rank_q[i] : '0);
			otag_c      = otag_c | (oldest_c[i] ? tag_q[i] : '0);
		end
		inv_c   = ~valid_q;
		free_c  = inv_c & (~inv_c + N'(1));
		cnt_dec = count_q - lot_pkg::CNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			match_s1  <= match_c;
			oldest_s1 <= oldest_c;
			free_s1   <= free_c;
			mrank_s1  <= mrank_c;
			otag_s1   <= otag_c;
			hit_s1    <= |match_c;
			full_s1   <= (inv_c == '0);
			empty_s1  <= (count_q == '0);
			newest_s1 <= (mrank_c == cnt_dec[lot_pkg::SLOT_W-1:0]);
		end
	end

	always_comb begin
		status_c = lot_pkg::ST_DONE;
		popped_c = '0;
		rm_en    = 1'b0;
		ins_en   = 1'b0;
		touch_en = 1'b0;
		rm_oh    = match_s1;
		rm_rank  = mrank_s1;
		case (kind_q)
			lot_pkg::K_ADD: begin
				if (hit_s1) begin
					status_c = lot_pkg::ST_NOOP;
				end else if (full_s1) begin
					status_c = lot_pkg::ST_FULL;
				end else begin
					ins_en = 1'b1;
				end
			end
			lot_pkg::K_REMOVE: begin
				if (hit_s1) begin
					rm_en = 1'b1;
				end else begin
					status_c = lot_pkg::ST_NOOP;
				end
			end
			lot_pkg::K_POKE: begin
				if (hit_s1) begin
					touch_en = !newest_s1;
				end else if (full_s1) begin
					status_c = lot_pkg::ST_FULL;
				end else begin
					ins_en = 1'b1;
				end
			end
			lot_pkg::K_POP: begin
				if (empty_s1) begin
					status_c = lot_pkg::ST_EMPTY;
				end else begin
					rm_en    = 1'b1;
					rm_oh    = oldest_s1;
					rm_rank  = '0;
					popped_c = otag_s1;
				end
			end
			default: begin
				status_c = lot_pkg::ST_NOOP;
			end
		endcase

		// Entries younger than the one leaving move one place toward the old end.
		for (int i = 0; i < N; i++) begin
			valid_n[i] = valid_q[i];
			rank_n[i]  = rank_q[i];
			if (rm_en && rm_oh[i]) begin
				valid_n[i] = 1'b0;
			end else if (touch_en && match_s1[i]) begin
				rank_n[i] = cnt_dec[lot_pkg::SLOT_W-1:0];
			end else if (ins_en && free_s1[i]) begin
				valid_n[i] = 1'b1;
				rank_n[i]  = count_q[lot_pkg::SLOT_W-1:0];
			end else if ((rm_en || touch_en) && valid_q[i] && (rank_q[i] > rm_rank)) begin
				rank_n[i] = rank_q[i] - lot_pkg::SLOT_W'(1);
			end
		end

		if (ins_en) begin
			cnt_n = count_q + lot_pkg::CNT_W'(1);
		end else if (rm_en) begin
			cnt_n = cnt_dec;
		end else begin
			cnt_n = count_q;
		end
		occ_wide = {lot_pkg::OCC_W'(0), cnt_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.update;
			if (cmd.update) begin
				valid_q <= valid_n;
				count_q <= cnt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			for (int i = 0; i < N; i++) begin
				rank_q[i] <= rank_n[i];
				if (ins_en && free_s1[i]) begin
					tag_q[i] <= req_tag_q;
				end
			end
			popped_q <= popped_c;
			status_q <= status_c;
			occ_q    <= occ_wide[lot_pkg::OCC_W-1:0];
		end
	end

	assign done       = done_q;
	assign popped_tag = popped_q;
	assign status     = status_q;
	assign occupancy  = occ_q;

endmodule
`default_nettype wire

// ----- sv/lru_order_tracker.sv -----
`default_nettype none
// Recency-ordered tag set; pop removes the least recently used tag.
// A request is kind and tag, taken at a rising edge where start is high
// and busy is low. Kinds: add, remove, poke (make newest or add), pop oldest.
// Every request gives exactly one result: done is high for one cycle with
// popped_tag, status and occupancy (tags held after the request).
// The block does a parallel tag lookup in the lookup state and the rank
// update in the update state that follows; done is registered from the
// update. A new request can be taken in the update state, so requests
// overlap; busy is high only during the lookup state.
// Each slot keeps its age rank, so removal and touch shift the ranks of all
// younger slots at once and no list walking is needed.
// Reset clears all slots and the count at once; the block can take a request
// as soon as reset is released. Results cannot be held off by the receiver,
// so done is a one-cycle strobe that must be captured when it occurs.
module lru_order_tracker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [lot_pkg::KIND_W-1:0]    kind,
	input  wire logic [lot_pkg::TAG_W-1:0]     tag,
	output logic                               done,
	output logic [lot_pkg::TAG_W-1:0]          popped_tag,
	output logic [lot_pkg::STATUS_W-1:0]       status,
	output logic [lot_pkg::OCC_W-1:0]          occupancy
);

	lot_pkg::cmd_t cmd;

	lot_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	lot_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.kind       (kind),
		.tag        (tag),
		.done       (done),
		.popped_tag (popped_tag),
		.status     (status),
		.occupancy  (occupancy)
	);

endmodule
`default_nettype wire

// ----- sv/lot_checker.sv -----
`default_nettype none
module lot_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          done,
	input wire logic [lot_pkg::TAG_W-1:0]     popped_tag,
	input wire logic [lot_pkg::STATUS_W-1:0]  status,
	input wire logic [lot_pkg::OCC_W-1:0]     occupancy
);

	// Every accepted request is followed by its result strobe.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("request accepted without a result three cycles later");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result strobe without a matching request");

	a_busy_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == lot_pkg::ST_EMPTY)) |-> ((occupancy == '0) && (popped_tag == '0)))
		else $error("pop on empty reported with tags held or a popped tag");

endmodule

bind lru_order_tracker lot_checker u_lot_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.popped_tag (popped_tag),
	.status     (status),
	.occupancy  (occupancy)
);
`default_nettype wire
